// File: src/fhp_pkg.sv
package fhp_pkg;

	// Header layout: type (2 bytes), length (2 bytes), checksum (4 bytes)
	localparam int HDR_BYTES = 8;
	localparam int HDR_IDX_W = $clog2(HDR_BYTES);

	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1016;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_BAD_SUM  = 3'd4
	} status_t;

endpackage

// File: src/fhp_ifs.sv
interface fhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fhp_out_if import fhp_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        payload_valid;
	logic        frame_done;
	status_t     status;
	logic [15:0] packet_type;
	logic [15:0] payload_length;
	logic [31:0] header_checksum;

	modport source (output valid, output payload_byte, output payload_valid,
		output frame_done, output status, output packet_type,
		output payload_length, output header_checksum, input ready);
	modport sink   (input valid, input payload_byte, input payload_valid,
		input frame_done, input status, input packet_type,
		input payload_length, input header_checksum, output ready);
endinterface

interface fhp_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] max_payload;

	modport source (output valid, output max_payload, input ready);
	modport sink   (input valid, input max_payload, output ready);
endinterface

// File: src/frame_header_parse_checksum.sv
// Channel   Dir  Word carries
// --------  ---  -----------------------------------------------------------
// rx        in   data_byte, last_byte (one buffer byte, flag on the final one)
// tx        out  payload_byte, payload_valid, frame_done, status,
//                packet_type, payload_length, header_checksum
// cfg       in   max_payload (largest accepted payload length)
//
// One word is taken per cycle. Each accepted byte is handled by one pass of
// logic from the rx port into the tx result register, so its result word (if
// any) shows on tx the cycle after acceptance.
// arst_n clears the parser to the header phase and max_payload to 1016.
// rx stalls only when the result register holds a word that tx has not taken;
// a byte that gives no result still needs that register free.
// cfg is always ready; write it only while the parser is idle.
module frame_header_parse_checksum import fhp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	fhp_in_if.sink      rx,
	fhp_out_if.source   tx,
	fhp_cfg_if.sink     cfg
);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_WAIT    = 2'd2
	} phase_t;

	// Parser state
	phase_t      phase_q, phase_n;
	logic [15:0] cnt_q, cnt_n;
	logic [15:0] type_q, type_n;
	logic [15:0] len_q, len_n;
	logic [31:0] chk_q, chk_n;
	logic [31:0] sum_q, sum_n;
	logic [15:0] max_q;

	// Header fields as held at this byte, before any re-arm
	logic [15:0] hdr_type;
	logic [15:0] hdr_len;
	logic [31:0] hdr_chk;

	// Result register
	logic        res_valid_q;
	logic [7:0]  res_byte_q;
	logic        res_pv_q;
	logic        res_done_q;
	status_t     res_st_q;
	logic [15:0] res_type_q;
	logic [15:0] res_len_q;
	logic [31:0] res_chk_q;

	// Next result word
	logic        emit;
	logic [7:0]  r_byte;
	logic        r_pv;
	logic        r_done;
	status_t     r_st;

	logic        rx_fire;
	logic        adv;
	logic [7:0]  b;

	assign b       = rx.data_byte;
	assign adv     = !res_valid_q || tx.ready;
	assign rx.ready = adv;
	assign rx_fire = rx.valid && adv;
	assign cfg.ready = 1'b1;

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		type_n  = type_q;
		len_n   = len_q;
		chk_n   = chk_q;
		sum_n   = sum_q;
		emit    = 1'b0;
		r_byte  = 8'd0;
		r_pv    = 1'b0;
		r_done  = 1'b0;
		r_st    = ST_OK;

		unique case (phase_q)
			PH_HEADER: begin
				// Drop the byte into its big-endian header slot
				case (cnt_q[HDR_IDX_W-1:0])
					3'd0:    type_n[15:8] = b;
					3'd1:    type_n[7:0]  = b;
					3'd2:    len_n[15:8]  = b;
					3'd3:    len_n[7:0]   = b;
					3'd4:    chk_n[31:24] = b;
					3'd5:    chk_n[23:16] = b;
					3'd6:    chk_n[15:8]  = b;
					default: chk_n[7:0]   = b;
				endcase
				if (cnt_q[HDR_IDX_W-1:0] == HDR_IDX_W'(HDR_BYTES - 1)) begin
					cnt_n = 16'd0;
					if (len_n > max_q) begin
						emit    = 1'b1;
						r_done  = 1'b1;
						r_st    = ST_TOO_LONG;
						phase_n = PH_WAIT;
					end else if (len_n == 16'd0) begin
						// empty payload: sum is still zero
						emit    = 1'b1;
						r_done  = 1'b1;
						r_st    = (chk_n != 32'd0 && sum_q != chk_n) ? ST_BAD_SUM : ST_OK;
						phase_n = PH_WAIT;
					end else if (rx.last_byte) begin
						emit   = 1'b1;
						r_done = 1'b1;
						r_st   = ST_TRUNC;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end else begin
					cnt_n = cnt_q + 16'd1;
					if (rx.last_byte) begin
						emit   = 1'b1;
						r_done = 1'b1;
						r_st   = ST_SHORT;
					end
				end
			end
			PH_PAYLOAD: begin
				// Pass the byte through and advance the wrapping sum
				sum_n  = sum_q + {24'd0, b};
				cnt_n  = cnt_q + 16'd1;
				emit   = 1'b1;
				r_byte = b;
				r_pv   = 1'b1;
				if (cnt_n >= len_q) begin
					r_done  = 1'b1;
					r_st    = (chk_q != 32'd0 && sum_n != chk_q) ? ST_BAD_SUM : ST_OK;
					phase_n = PH_WAIT;
				end else if (rx.last_byte) begin
					r_done = 1'b1;
					r_st   = ST_TRUNC;
				end
			end
			default: begin
				// wait phase: ignore trailing bytes until the last one
			end
		endcase

		// The result word reports the header as it stands before the re-arm
		hdr_type = type_n;
		hdr_len  = len_n;
		hdr_chk  = chk_n;

		// Re-arm on the final byte, after the result is formed
		if (rx.last_byte) begin
			phase_n = PH_HEADER;
			cnt_n   = 16'd0;
			type_n  = 16'd0;
			len_n   = 16'd0;
			chk_n   = 32'd0;
			sum_n   = 32'd0;
		end
	end

	// Parser state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= 16'd0;
			type_q  <= 16'd0;
			len_q   <= 16'd0;
			chk_q   <= 32'd0;
			sum_q   <= 32'd0;
			max_q   <= MAX_PAYLOAD_RESET;
		end else begin
			if (rx_fire) begin
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
				type_q  <= type_n;
				len_q   <= len_n;
				chk_q   <= chk_n;
				sum_q   <= sum_n;
			end
			if (cfg.valid) begin
				max_q <= cfg.max_payload;
			end
		end
	end

	// Result register: load whenever it is free or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= rx_fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire && emit) begin
			res_byte_q <= r_byte;
			res_pv_q   <= r_pv;
			res_done_q <= r_done;
			res_st_q   <= r_st;
			// header fields as held at this byte, before any re-arm
			res_type_q <= hdr_type;
			res_len_q  <= hdr_len;
			res_chk_q  <= hdr_chk;
		end
	end

	assign tx.valid           = res_valid_q;
	assign tx.payload_byte    = res_byte_q;
	assign tx.payload_valid   = res_pv_q;
	assign tx.frame_done      = res_done_q;
	assign tx.status          = res_st_q;
	assign tx.packet_type     = res_type_q;
	assign tx.payload_length  = res_len_q;
	assign tx.header_checksum = res_chk_q;

	// The payload count never reaches the length while still in payload phase
	a_payload_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> cnt_q < len_q)
		else $error("payload count reached length without leaving payload phase");

	// The header count stays inside the header
	a_header_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> cnt_q < 16'(HDR_BYTES))
		else $error("header byte count out of range");

	// The final byte of a buffer always re-arms the parser
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fire && rx.last_byte |=> phase_q == PH_HEADER && cnt_q == 16'd0 && sum_q == 32'd0)
		else $error("parser not re-armed after last byte");

	// Every result word carries a payload byte or a frame end
	a_word_content: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid |-> tx.payload_valid || tx.frame_done)
		else $error("empty result word");

	// Status is OK unless the word ends a frame
	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && !tx.frame_done |-> tx.status == ST_OK)
		else $error("error status on a word that does not end a frame");

endmodule
